### sv/fpid_pkg.sv
`default_nettype none
package fpid_pkg;

    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned DRIVE_W = 16;
    localparam int unsigned ERR_W   = 17;
    localparam int unsigned FILT_W  = 26;
    localparam int unsigned DIFF_W  = 27;
    localparam int unsigned INTEG_W = 32;
    localparam int unsigned OPA_W   = 17;
    localparam int unsigned OPB_W   = 33;
    localparam int unsigned PROD_W  = OPA_W + OPB_W;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic signed [OPA_W-1:0]   C_FILT_NEW  = 17'sd179;
    localparam logic signed [OPA_W-1:0]   C_FILT_OLD  = 17'sd77;
    localparam logic signed [OPB_W-1:0]   C_INTEG_MAX = 33'sd256000;
    localparam logic signed [OPB_W-1:0]   C_INTEG_MIN = -33'sd2147483648;
    localparam logic signed [PROD_W-17:0] C_DRIVE_MAX = 34'sd100;
    localparam logic signed [PROD_W-17:0] C_DRIVE_MIN = -34'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP  = 2'd0,
        REG_GAIN_INTEG = 2'd1,
        REG_GAIN_DERIV = 2'd2,
        REG_NONE       = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_PREV,
        S_MUL_ERR,
        S_FILT,
        S_PROP,
        S_DERIV,
        S_INTEG,
        S_ACC,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef struct packed {
        logic    mul_en;
        t_acc_op acc_op;
    } t_mac_ctl;

endpackage
`default_nettype wire

### sv/fpid_in_if.sv
`default_nettype none
interface fpid_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] target_speed;
    logic signed [15:0] measured_speed;

    modport source (output valid, output target_speed, output measured_speed, input ready);
    modport sink   (input valid, input target_speed, input measured_speed, output ready);
endinterface
`default_nettype wire

### sv/fpid_out_if.sv
`default_nettype none
interface fpid_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive_value;

    modport source (output valid, output drive_value, input ready);
    modport sink   (input valid, input drive_value, output ready);
endinterface
`default_nettype wire

### sv/fpid_mac.sv
`default_nettype none
module fpid_mac
    import fpid_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_mac_ctl                 i_ctl,
    input  wire logic signed [OPA_W-1:0]  i_op_a,
    input  wire logic signed [OPB_W-1:0]  i_op_b,
    output logic signed [PROD_W-1:0]      o_prod,
    output logic signed [PROD_W-1:0]      o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
        end
        case (i_ctl.acc_op)
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            default:  r_acc <= r_acc;
        endcase
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule
`default_nettype wire

### sv/filtered_pid_speed_controller_core.sv
// An accepted input steps the sequencer through MUL_PREV, MUL_ERR, FILT, PROP, DERIV, INTEG,
// ACC and DONE, and a new input is taken only once it is back in IDLE. All five multiplies
// share one 17x33 multiply-accumulate unit stepped by the sequencer.
// The output register lets the next input be taken while a result waits.
// Reset clears the gains, the previous filtered error, the integral and the output valid flag.
`default_nettype none
module filtered_pid_speed_controller_core
    import fpid_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [GAIN_W-1:0]    i_cfg_data,
    fpid_in_if.sink                   i_in,
    fpid_out_if.source                o_out
);

    t_state                     r_state, n_state;
    logic signed [GAIN_W-1:0]   r_gain_prop, r_gain_integ, r_gain_deriv;
    logic signed [FILT_W-1:0]   r_fprev;
    logic signed [INTEG_W-1:0]  r_integ;
    logic signed [ERR_W-1:0]    r_err;
    logic signed [FILT_W-1:0]   r_f;
    logic signed [DIFF_W-1:0]   r_diff;
    logic                       r_out_valid;
    logic signed [DRIVE_W-1:0]  r_drive;

    t_mac_ctl                   mac_ctl;
    logic signed [OPA_W-1:0]    op_a;
    logic signed [OPB_W-1:0]    op_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   acc;

    logic                       in_acc;
    logic                       done_adv;
    logic signed [OPB_W-1:0]    integ_sum;
    logic signed [INTEG_W-1:0]  integ_sat;
    logic signed [PROD_W-17:0]  quo;
    logic signed [DRIVE_W-1:0]  drive_sat;

    assign in_acc   = i_in.valid && i_in.ready;
    assign done_adv = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (in_acc) n_state = S_MUL_PREV;
            S_MUL_PREV: n_state = S_MUL_ERR;
            S_MUL_ERR:  n_state = S_FILT;
            S_FILT:     n_state = S_PROP;
            S_PROP:     n_state = S_DERIV;
            S_DERIV:    n_state = S_INTEG;
            S_INTEG:    n_state = S_ACC;
            S_ACC:      n_state = S_DONE;
            S_DONE:     if (done_adv) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mac_ctl = '{mul_en: 1'b0, acc_op: ACC_HOLD};
        op_a    = '0;
        op_b    = '0;
        case (r_state)
            S_MUL_PREV: begin
                mac_ctl.mul_en = 1'b1;
                op_a = C_FILT_OLD;
                op_b = {{(OPB_W-FILT_W){r_fprev[FILT_W-1]}}, r_fprev};
            end
            S_MUL_ERR: begin
                mac_ctl.mul_en = 1'b1;
                op_a = C_FILT_NEW;
                op_b = {{(OPB_W-ERR_W){r_err[ERR_W-1]}}, r_err};
            end
            S_PROP: begin
                mac_ctl.mul_en = 1'b1;
                op_a = {r_gain_prop[GAIN_W-1], r_gain_prop};
                op_b = {{(OPB_W-FILT_W){r_f[FILT_W-1]}}, r_f};
            end
            S_DERIV: begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.acc_op = ACC_LOAD;
                op_a = {r_gain_deriv[GAIN_W-1], r_gain_deriv};
                op_b = {{(OPB_W-DIFF_W){r_diff[DIFF_W-1]}}, r_diff};
            end
            S_INTEG: begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.acc_op = ACC_ADD;
                op_a = {r_gain_integ[GAIN_W-1], r_gain_integ};
                op_b = {r_integ[INTEG_W-1], r_integ};
            end
            S_ACC: begin
                mac_ctl.acc_op = ACC_ADD;
            end
            default: begin
                mac_ctl = '{mul_en: 1'b0, acc_op: ACC_HOLD};
            end
        endcase
    end

    fpid_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_op_a (op_a),
        .i_op_b (op_b),
        .o_prod (prod),
        .o_acc  (acc)
    );

    always_comb begin
        integ_sum = {r_integ[INTEG_W-1], r_integ} + {{(OPB_W-FILT_W){r_f[FILT_W-1]}}, r_f};
        if (integ_sum > C_INTEG_MAX) begin
            integ_sum = C_INTEG_MAX;
        end else if (integ_sum < C_INTEG_MIN) begin
            integ_sum = C_INTEG_MIN;
        end
        integ_sat = integ_sum[INTEG_W-1:0];
    end

    always_comb begin
        quo = acc[PROD_W-1:16];
        if (acc[PROD_W-1] && (acc[15:0] != '0)) begin
            quo = quo + 34'sd1;
        end
        if (quo > C_DRIVE_MAX) begin
            drive_sat = C_DRIVE_MAX[DRIVE_W-1:0];
        end else if (quo < C_DRIVE_MIN) begin
            drive_sat = C_DRIVE_MIN[DRIVE_W-1:0];
        end else begin
            drive_sat = quo[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_gain_prop  <= '0;
            r_gain_integ <= '0;
            r_gain_deriv <= '0;
            r_fprev      <= '0;
            r_integ      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_GAIN_PROP:  r_gain_prop  <= i_cfg_data;
                    REG_GAIN_INTEG: r_gain_integ <= i_cfg_data;
                    REG_GAIN_DERIV: r_gain_deriv <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_PROP) begin
                r_fprev <= r_f;
                r_integ <= integ_sat;
            end
            if (done_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_err <= {i_in.target_speed[SPEED_W-1], i_in.target_speed}
                           - {i_in.measured_speed[SPEED_W-1], i_in.measured_speed};
                end
            end
            S_MUL_ERR: r_f <= prod[33:8];
            S_FILT:    r_f <= r_f + prod[FILT_W-1:0];
            S_PROP:    r_diff <= {r_f[FILT_W-1], r_f} - {r_fprev[FILT_W-1], r_fprev};
            S_DONE: begin
                if (done_adv) begin
                    r_drive <= drive_sat;
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.drive_value = r_drive;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_MUL_PREV))
        else $error("accepted input did not start the sequence");

    a_integ_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_integ <= $signed(C_INTEG_MAX[INTEG_W-1:0]))
        else $error("integral above its upper clamp");

    a_drive_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_drive <= 16'sd100))
        else $error("drive above its upper clamp");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_adv |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished transaction not presented on output");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_out_valid && !o_out.ready |=> (r_state == S_DONE))
        else $error("sequencer left DONE while output still pending");

endmodule
`default_nettype wire
